FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BGQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define BGQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Check on the cycle after reset was sampled high.
`define BGQ_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
      else $error("post-reset check failed");

`endif

FILE: src/bgq_pkg.sv
// Types, constants and helper functions of the glyph quad generator.
`default_nettype none

package bgq_pkg;

   // Glyph width store
   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

   // Item codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CHAR = 1'b1;

   // Register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_CHAR    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CELL_WIDTH   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_CELL_HEIGHT  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(4);

   // Vertex sequencing
   localparam int VERTS_PER_GLYPH = 6;
   localparam int VTX_W = $clog2(VERTS_PER_GLYPH);
   localparam logic [VTX_W-1:0] VTX_LAST = VTX_W'(VERTS_PER_GLYPH - 1);

   // Texture coordinates
   localparam int TEX_W   = 17;
   localparam int TEX_ONE = 65536;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Shared divider
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 13;
   localparam int DIV_CNT_W = 6;
   localparam int ITERS_PER_ROW = 13;
   localparam int ITERS_ROW     = 8;
   localparam int ITERS_ADV     = 39;
   localparam int ITERS_TEX_U   = 30;
   localparam int ITERS_TEX_V   = 35;
   localparam int MUL_A_W = 31;
   localparam int MUL_B_W = 13;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic [7:0]  base_char;
      logic [10:0] cell_width;
      logic [10:0] cell_height;
      logic [12:0] image_width;
      logic [12:0] image_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      base_char:    8'd32,
      cell_width:   11'd16,
      cell_height:  11'd16,
      image_width:  13'd256,
      image_height: 13'd256
   };

   typedef struct packed {
      logic               op;
      logic [7:0]         char_code;
      logic [7:0]         glyph_width;
      logic               start_text;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        glyph_size;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
      logic               last_vertex;
   } rsp_type;

   typedef struct packed {
      logic               start_text;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        glyph_size;
      logic [7:0]         char_code;
      logic [7:0]         glyph_width;
   } glyph_item_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CNT_W-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_PER_ROW,
      PH_ROW,
      PH_ADV,
      PH_U0,
      PH_U1,
      PH_V0,
      PH_V1
   } phase_type;

   function automatic phase_type phase_after(input phase_type ph);
      case (ph)
         PH_PER_ROW: phase_after = PH_ROW;
         PH_ROW:     phase_after = PH_ADV;
         PH_ADV:     phase_after = PH_U0;
         PH_U0:      phase_after = PH_U1;
         PH_U1:      phase_after = PH_V0;
         PH_V0:      phase_after = PH_V1;
         default:    phase_after = PH_PER_ROW;
      endcase
   endfunction

   // Clamp a texture quotient to 1.0
   function automatic logic [TEX_W-1:0] tex_sat(input logic [DIV_NUM_W-1:0] q);
      if (q > DIV_NUM_W'(TEX_ONE)) begin
         tex_sat = TEX_W'(TEX_ONE);
      end else begin
         tex_sat = q[TEX_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/bgq_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module bgq_div (
   input  logic                clock,
   input  logic                reset,
   input  bgq_pkg::div_req_type div_req,
   output bgq_pkg::div_rsp_type div_rsp
);
   import bgq_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // Numerator arrives left-aligned; quotient bits shift in from the bottom
   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.iters;
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: src/bgq_fifo.sv
// Short queue of character items between front and back.
`default_nettype none

module bgq_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bgq_pkg::glyph_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    q_valid,
   output bgq_pkg::glyph_item_type q_head
);
   import bgq_pkg::*;

   glyph_item_type         slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + QUEUE_PTR_W'(1);
      end
   endfunction

   assign full    = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: src/bgq_front.sv
// Input stage: width table loads and character lookup.
`default_nettype none

module bgq_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bgq_pkg::req_type        req_data,
   output logic                    push,
   output bgq_pkg::glyph_item_type push_item,
   input  logic                    q_full
);
   import bgq_pkg::*;

   logic [7:0]             width_mem [GLYPH_COUNT];
   logic [7:0]             rd_width_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_hit_ff;
   glyph_item_type         s1_item_ff;
   logic                   accept;
   logic                   accept_load;
   logic                   accept_char;
   logic                   in_range;
   logic [GLYPH_IDX_W-1:0] mem_idx;

   assign push        = s1_valid_ff && !q_full;
   assign req_ready   = !s1_valid_ff || !q_full;
   assign accept      = req_valid && req_ready;
   assign accept_load = accept && (req_data.op == OP_LOAD);
   assign accept_char = accept && (req_data.op == OP_CHAR);
   assign in_range    = {1'b0, req_data.char_code} < 9'(GLYPH_COUNT);
   assign mem_idx     = req_data.char_code[GLYPH_IDX_W-1:0];

   // Load writes and character reads share one port; order of items is kept
   always_ff @(posedge clock) begin
      if (accept_load && in_range) begin
         width_mem[mem_idx] <= req_data.glyph_width;
      end
      if (accept_char) begin
         rd_width_ff <= width_mem[mem_idx];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept_char) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_char) begin
         s1_hit_ff              <= in_range;
         s1_item_ff.start_text  <= req_data.start_text;
         s1_item_ff.pos_x       <= req_data.pos_x;
         s1_item_ff.pos_y       <= req_data.pos_y;
         s1_item_ff.pos_z       <= req_data.pos_z;
         s1_item_ff.glyph_size  <= req_data.glyph_size;
         s1_item_ff.char_code   <= req_data.char_code;
         s1_item_ff.glyph_width <= '0;
      end
   end

   // Codes past the table read as zero width
   always_comb begin
      push_item             = s1_item_ff;
      push_item.glyph_width = s1_hit_ff ? rd_width_ff : 8'd0;
   end

endmodule

`default_nettype wire

FILE: src/bgq_back.sv
// Back end: glyph geometry through a shared divider and vertex emission.
`default_nettype none

module bgq_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bgq_pkg::cfg_type        cfg,
   input  logic                    q_valid,
   input  bgq_pkg::glyph_item_type q_head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bgq_pkg::rsp_type        rsp_data
);
   import bgq_pkg::*;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [VTX_W-1:0]   vtx_ff, vtx_in;
   logic signed [31:0] cursor_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic [7:0]         code_ff;
   logic [7:0]         w_ff;
   logic signed [31:0] py_ff;
   logic signed [31:0] pz_ff;
   logic [30:0]        size_ff;
   logic [12:0]        per_row_ff;
   logic [7:0]         row_ff;
   logic [7:0]         col_ff;
   logic signed [31:0] xr_ff;
   logic signed [31:0] yt_ff;
   logic [TEX_W-1:0]   u0_ff, u1_ff, v0_ff, v1_ff;

   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic                 load_out;
   logic [10:0]          cw_eff, ch_eff;
   logic [12:0]          iw_eff, ih_eff;
   logic [7:0]           idx;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   product;
   logic [DIV_NUM_W-1:0] num_aligned;
   logic [DIV_DEN_W-1:0] den_sel;
   logic [DIV_CNT_W-1:0] iters_sel;
   logic signed [40:0]   xr_sum;
   logic signed [32:0]   yt_sum;
   logic                 use_right;
   logic                 use_top;

   bgq_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Zero sizes act as one
   assign cw_eff = (cfg.cell_width == '0) ? 11'd1 : cfg.cell_width;
   assign ch_eff = (cfg.cell_height == '0) ? 11'd1 : cfg.cell_height;
   assign iw_eff = (cfg.image_width == '0) ? 13'd1 : cfg.image_width;
   assign ih_eff = (cfg.image_height == '0) ? 13'd1 : cfg.image_height;
   assign idx    = (code_ff >= cfg.base_char) ? code_ff - cfg.base_char : 8'd0;

   // One multiplier feeds the numerators of the advance and texture divisions
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (phase_ff)
         PH_ADV: begin
            mul_a = size_ff;
            mul_b = MUL_B_W'(w_ff);
         end
         PH_U0, PH_U1: begin
            mul_a = MUL_A_W'(col_ff);
            mul_b = MUL_B_W'(cw_eff);
         end
         PH_V0: begin
            mul_a = MUL_A_W'(row_ff);
            mul_b = MUL_B_W'(ch_eff);
         end
         PH_V1: begin
            mul_a = MUL_A_W'(row_ff) + MUL_A_W'(1);
            mul_b = MUL_B_W'(ch_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // Left-align each numerator by its bit count
   always_comb begin
      num_aligned = '0;
      den_sel     = DIV_DEN_W'(1);
      iters_sel   = DIV_CNT_W'(1);
      case (phase_ff)
         PH_PER_ROW: begin
            num_aligned = DIV_NUM_W'(iw_eff) << (DIV_NUM_W - ITERS_PER_ROW);
            den_sel     = DIV_DEN_W'(cw_eff);
            iters_sel   = DIV_CNT_W'(ITERS_PER_ROW);
         end
         PH_ROW: begin
            num_aligned = DIV_NUM_W'(idx) << (DIV_NUM_W - ITERS_ROW);
            den_sel     = per_row_ff;
            iters_sel   = DIV_CNT_W'(ITERS_ROW);
         end
         PH_ADV: begin
            num_aligned = DIV_NUM_W'(product) << (DIV_NUM_W - ITERS_ADV);
            den_sel     = DIV_DEN_W'(cw_eff);
            iters_sel   = DIV_CNT_W'(ITERS_ADV);
         end
         PH_U0: begin
            num_aligned = DIV_NUM_W'(product) << (DIV_NUM_W - ITERS_TEX_U + 16);
            den_sel     = iw_eff;
            iters_sel   = DIV_CNT_W'(ITERS_TEX_U);
         end
         PH_U1: begin
            num_aligned = (DIV_NUM_W'(product) + DIV_NUM_W'(w_ff))
                          << (DIV_NUM_W - ITERS_TEX_U + 16);
            den_sel     = iw_eff;
            iters_sel   = DIV_CNT_W'(ITERS_TEX_U);
         end
         PH_V0, PH_V1: begin
            num_aligned = DIV_NUM_W'(product) << (DIV_NUM_W - ITERS_TEX_V + 16);
            den_sel     = ih_eff;
            iters_sel   = DIV_CNT_W'(ITERS_TEX_V);
         end
         default: begin
            num_aligned = '0;
            den_sel     = DIV_DEN_W'(1);
            iters_sel   = DIV_CNT_W'(1);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      vtx_in   = vtx_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      div_req  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               phase_in = PH_PER_ROW;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            div_req.start = 1'b1;
            div_req.num   = num_aligned;
            div_req.den   = den_sel;
            div_req.iters = iters_sel;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (phase_ff == PH_V1) begin
                  vtx_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  phase_in = phase_after(phase_ff);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               if (vtx_ff == VTX_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  vtx_in = vtx_ff + VTX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PER_ROW;
         vtx_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop && q_head.start_text) begin
            cursor_ff <= q_head.pos_x;
         end else if (load_out && vtx_ff == VTX_LAST) begin
            cursor_ff <= xr_ff;
         end
      end
   end

   // Saturating position sums
   assign xr_sum = 41'(cursor_ff) + $signed({2'b00, div_rsp.quot[38:0]});
   assign yt_sum = 33'(py_ff) + $signed({2'b00, size_ff});

   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff <= q_head.char_code;
         w_ff    <= q_head.glyph_width;
         py_ff   <= q_head.pos_y;
         pz_ff   <= q_head.pos_z;
         size_ff <= q_head.glyph_size;
      end
      if (state_ff == ST_WAIT && div_rsp.done) begin
         case (phase_ff)
            PH_PER_ROW: begin
               per_row_ff <= (div_rsp.quot == '0) ? 13'd1 : div_rsp.quot[12:0];
            end
            PH_ROW: begin
               row_ff <= div_rsp.quot[7:0];
               col_ff <= div_rsp.rem[7:0];
            end
            PH_ADV: begin
               xr_ff <= (xr_sum > 41'sd2147483647) ? 32'sh7FFFFFFF : xr_sum[31:0];
               yt_ff <= (yt_sum > 33'sd2147483647) ? 32'sh7FFFFFFF : yt_sum[31:0];
            end
            PH_U0:   u0_ff <= tex_sat(div_rsp.quot);
            PH_U1:   u1_ff <= tex_sat(div_rsp.quot);
            PH_V0:   v0_ff <= tex_sat(div_rsp.quot);
            PH_V1:   v1_ff <= tex_sat(div_rsp.quot);
            default: v1_ff <= v1_ff;
         endcase
      end
      if (load_out) begin
         rsp_data_ff.vert_x      <= use_right ? xr_ff : cursor_ff;
         rsp_data_ff.vert_y      <= use_top ? yt_ff : py_ff;
         rsp_data_ff.vert_z      <= pz_ff;
         rsp_data_ff.tex_u       <= use_right ? u1_ff : u0_ff;
         rsp_data_ff.tex_v       <= use_top ? v0_ff : v1_ff;
         rsp_data_ff.last_vertex <= vtx_ff == VTX_LAST;
      end
   end

   // Corner order: top-left, top-right, bottom-left, bottom-left, top-right, bottom-right
   assign use_right = vtx_ff inside {VTX_W'(1), VTX_W'(4), VTX_W'(5)};
   assign use_top   = vtx_ff inside {VTX_W'(0), VTX_W'(1), VTX_W'(4)};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: src/bitmap_glyph_quad_generator.sv
// Top level of the bitmap glyph quad generator: register file and front/back wiring.
// A width load only writes the front end's width table. A character goes through seven
// divisions on the shared divider in the back end, which retires one quotient bit a cycle;
// its six vertices leave after the last division, as the result side accepts them.
// Synchronous reset restores the registers, zeroes the cursor and empties the queue.
`default_nettype none

module bitmap_glyph_quad_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bgq_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bgq_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [bgq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgq_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bgq_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           push;
   glyph_item_type push_item;
   logic           q_full;
   logic           q_valid;
   glyph_item_type q_head;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_BASE_CHAR:    cfg_in.base_char    = csr_wdata[7:0];
            REG_CELL_WIDTH:   cfg_in.cell_width   = csr_wdata[10:0];
            REG_CELL_HEIGHT:  cfg_in.cell_height  = csr_wdata[10:0];
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[12:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[12:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bgq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   bgq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_head    (q_head)
   );

   bgq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: src/bgq_checker.sv
// Port-level checks of the glyph quad generator and their binding.
`default_nettype none
`include "assert_macros.svh"

module bgq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bgq_pkg::rsp_type rsp_data
);
   import bgq_pkg::*;

   logic [VTX_W-1:0]   cnt_ff;
   logic signed [31:0] z_prev_ff;
   logic               rsp_take;
   logic               rsp_stall;
   logic               last_ok;
   logic               z_same;
   logic               tex_ok;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign last_ok   = rsp_data.last_vertex == (cnt_ff == VTX_LAST);
   assign z_same    = rsp_data.vert_z == z_prev_ff;
   assign tex_ok    = rsp_data.tex_u <= TEX_W'(TEX_ONE) && rsp_data.tex_v <= TEX_W'(TEX_ONE);

   // Track position within the current glyph's six vertices
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (rsp_take) begin
         cnt_ff <= (cnt_ff == VTX_LAST) ? '0 : cnt_ff + VTX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         z_prev_ff <= rsp_data.vert_z;
      end
   end

   `BGQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `BGQ_ASSERT_SAME(a_last_sixth, clock, reset, rsp_take, last_ok)
   `BGQ_ASSERT_SAME(a_depth_const, clock, reset, rsp_take && cnt_ff != '0, z_same)
   `BGQ_ASSERT_SAME(a_tex_range, clock, reset, rsp_valid, tex_ok)
   `BGQ_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, reset || !rsp_valid)

endmodule

bind bitmap_glyph_quad_generator bgq_checker u_bgq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the bitmap glyph quad generator.
`timescale 1ns / 100ps

module testbench;
   import bgq_pkg::*;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 250;
   localparam int RANDOM_PER_CFG = 19;
   localparam int PRINT_LIMIT   = 30;
   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;

   // Corner values of one glyph quad; the six vertices are built from these
   typedef struct packed {
      logic [31:0]      xl;
      logic [31:0]      xr;
      logic [31:0]      yt;
      logic [31:0]      yb;
      logic [31:0]      z;
      logic [TEX_W-1:0] u0;
      logic [TEX_W-1:0] u1;
      logic [TEX_W-1:0] v0;
      logic [TEX_W-1:0] v1;
   } quad_corners_t;

   typedef struct packed {
      req_type       req;
      logic          typed;
      quad_corners_t quad;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state
   cfg_type cfg_shadow = CFG_RESET;
   logic signed [31:0] cursor_shadow = '0;
   logic [7:0] width_mem [0:GLYPH_COUNT-1];
   bit width_known [0:GLYPH_COUNT-1];
   logic [7:0] known_codes [$];
   rsp_type vertex_queue [$];

   bit steady = 1'b0;
   int ready_hold = 0;
   int error_count = 0;
   int loads_sent = 0;
   int glyphs_sent = 0;
   int vertices_seen = 0;
   int settings_used = 0;

   bitmap_glyph_quad_generator DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(2_000_000);
      $display("testbench NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   // Mostly short idles, now and then a long one
   function automatic int idle_len();
      int pick;
      if (steady) begin
         return 0;
      end
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         return 0;
      end else if (pick < 18) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] floor_one(input logic [31:0] v);
      return (v == 0) ? 32'd1 : v;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > POS_MAX) begin
         return 32'h7FFF_FFFF;
      end else if (v < POS_MIN) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [TEX_W-1:0] tex_frac(input logic [63:0] pixels,
                                                 input logic [31:0] extent);
      logic [63:0] t;
      t = (pixels << 16) / 64'(extent);
      return (t > 64'(TEX_ONE)) ? TEX_W'(TEX_ONE) : t[TEX_W-1:0];
   endfunction

   // Work out the quad for one character and advance the cursor
   function automatic quad_corners_t render_glyph(input req_type r);
      quad_corners_t q;
      logic [31:0] cw, ch, iw, ih, per_row, idx, row, col, w;
      logic [63:0] adv;
      logic [31:0] xr;
      cw = floor_one(32'(cfg_shadow.cell_width));
      ch = floor_one(32'(cfg_shadow.cell_height));
      iw = floor_one(32'(cfg_shadow.image_width));
      ih = floor_one(32'(cfg_shadow.image_height));
      per_row = floor_one(iw / cw);
      idx = (r.char_code >= cfg_shadow.base_char) ?
            32'(r.char_code) - 32'(cfg_shadow.base_char) : 32'd0;
      row = idx / per_row;
      col = idx % per_row;
      w = 32'(width_mem[r.char_code]);
      if (r.start_text) begin
         cursor_shadow = r.pos_x;
      end
      adv = (64'(w) * 64'(r.glyph_size)) / 64'(cw);
      xr = clamp32(longint'($signed(cursor_shadow)) + longint'(adv));
      q.xl = cursor_shadow;
      q.xr = xr;
      q.yt = clamp32(longint'($signed(r.pos_y)) + longint'(r.glyph_size));
      q.yb = r.pos_y;
      q.z  = r.pos_z;
      q.u0 = tex_frac(64'(col) * 64'(cw), iw);
      q.u1 = tex_frac(64'(col) * 64'(cw) + 64'(w), iw);
      q.v0 = tex_frac(64'(row) * 64'(ch), ih);
      q.v1 = tex_frac((64'(row) + 64'd1) * 64'(ch), ih);
      cursor_shadow = xr;
      return q;
   endfunction

   function automatic void queue_quad(input quad_corners_t q);
      vertex_queue.insert(vertex_queue.size(), rsp_type'{q.xl, q.yt, q.z, q.u0, q.v0, 1'b0});
      vertex_queue.insert(vertex_queue.size(), rsp_type'{q.xr, q.yt, q.z, q.u1, q.v0, 1'b0});
      vertex_queue.insert(vertex_queue.size(), rsp_type'{q.xl, q.yb, q.z, q.u0, q.v1, 1'b0});
      vertex_queue.insert(vertex_queue.size(), rsp_type'{q.xl, q.yb, q.z, q.u0, q.v1, 1'b0});
      vertex_queue.insert(vertex_queue.size(), rsp_type'{q.xr, q.yt, q.z, q.u1, q.v0, 1'b0});
      vertex_queue.insert(vertex_queue.size(), rsp_type'{q.xr, q.yb, q.z, q.u1, q.v1, 1'b1});
   endfunction

   function automatic stim_row_t load_row(input logic [7:0] code, input logic [7:0] gw);
      stim_row_t row;
      row = '0;
      row.req.op = OP_LOAD;
      row.req.char_code = code;
      row.req.glyph_width = gw;
      row.req.pos_x = 32'hFFFF_FFFF;
      row.req.glyph_size = 31'h7FFF_FFFF;
      return row;
   endfunction

   function automatic stim_row_t char_row(input logic [7:0] code, input logic start,
                                          input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz, input logic [30:0] size);
      stim_row_t row;
      row = '0;
      row.req.op = OP_CHAR;
      row.req.char_code = code;
      row.req.glyph_width = 8'hA5;
      row.req.start_text = start;
      row.req.pos_x = px;
      row.req.pos_y = py;
      row.req.pos_z = pz;
      row.req.glyph_size = size;
      return row;
   endfunction

   function automatic stim_row_t typed_row(input stim_row_t row, input quad_corners_t q);
      row.typed = 1'b1;
      row.quad = q;
      return row;
   endfunction

   function automatic logic [31:0] small_fixed();
      logic [31:0] r;
      r = $urandom;
      return {{12{r[19]}}, r[19:0]};
   endfunction

   function automatic stim_row_t random_row();
      stim_row_t row;
      row = '0;
      row.req.char_code = 8'($urandom);
      row.req.glyph_width = 8'($urandom);
      row.req.start_text = ($urandom_range(0, 3) == 0);
      row.req.pos_x = ($urandom_range(0, 2) == 0) ? 32'($urandom) : small_fixed();
      row.req.pos_y = ($urandom_range(0, 2) == 0) ? 32'($urandom) : small_fixed();
      row.req.pos_z = 32'($urandom);
      row.req.glyph_size = ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                           31'($urandom_range(0, 32'h0040_0000));
      // Characters only use table entries that were loaded
      if (known_codes.size() == 0 || $urandom_range(0, 9) < 3) begin
         row.req.op = OP_LOAD;
      end else begin
         row.req.op = OP_CHAR;
         row.req.char_code = known_codes[$urandom_range(0, known_codes.size() - 1)];
      end
      return row;
   endfunction

   task automatic send_item(input stim_row_t row);
      int gap;
      quad_corners_t q;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= row.req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (row.req.op == OP_LOAD) begin
         width_mem[row.req.char_code] = row.req.glyph_width;
         if (!width_known[row.req.char_code]) begin
            width_known[row.req.char_code] = 1'b1;
            known_codes.insert(known_codes.size(), row.req.char_code);
         end
         loads_sent++;
      end else begin
         q = render_glyph(row.req);
         if (row.typed) begin
            q = row.quad;
         end
         queue_quad(q);
         glyphs_sent++;
      end
   endtask

   // Hold off the sender until every vertex is out and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      drain();
      for (logic [CSR_IDX_W-1:0] idx = REG_BASE_CHAR; idx <= REG_IMAGE_HEIGHT; idx++) begin
         csr_write_en <= 1'b1;
         csr_index <= idx;
         case (idx)
            REG_BASE_CHAR:    csr_wdata <= CSR_DATA_W'(s.base_char);
            REG_CELL_WIDTH:   csr_wdata <= CSR_DATA_W'(s.cell_width);
            REG_CELL_HEIGHT:  csr_wdata <= CSR_DATA_W'(s.cell_height);
            REG_IMAGE_WIDTH:  csr_wdata <= CSR_DATA_W'(s.image_width);
            default:          csr_wdata <= CSR_DATA_W'(s.image_height);
         endcase
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      cfg_shadow = s;
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (steady) begin
         rsp_ready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin : pick_ready
         int stall;
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            ready_hold <= stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 7);
         end
      end
   end

   always @(posedge clock) begin : check_vertices
      rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (vertex_queue.size() == 0) begin
            report_mismatch($sformatf("vertex with nothing expected: %h", got));
         end else begin
            want = vertex_queue.pop_front();
            if (got.vert_x !== want.vert_x)
               report_mismatch($sformatf("vertex %0d x got %h want %h",
                                         vertices_seen, got.vert_x, want.vert_x));
            if (got.vert_y !== want.vert_y)
               report_mismatch($sformatf("vertex %0d y got %h want %h",
                                         vertices_seen, got.vert_y, want.vert_y));
            if (got.vert_z !== want.vert_z)
               report_mismatch($sformatf("vertex %0d z got %h want %h",
                                         vertices_seen, got.vert_z, want.vert_z));
            if (got.tex_u !== want.tex_u)
               report_mismatch($sformatf("vertex %0d u got %h want %h",
                                         vertices_seen, got.tex_u, want.tex_u));
            if (got.tex_v !== want.tex_v)
               report_mismatch($sformatf("vertex %0d v got %h want %h",
                                         vertices_seen, got.tex_v, want.tex_v));
            if (got.last_vertex !== want.last_vertex)
               report_mismatch($sformatf("vertex %0d last got %b want %b",
                                         vertices_seen, got.last_vertex, want.last_vertex));
         end
         vertices_seen++;
      end
   end

   initial begin : stimulus
      stim_row_t directed_rows [$];
      cfg_type phase_cfg [5];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: 32 base, 16x16 cells, 256x256 sheet
      directed_rows.insert(directed_rows.size(), load_row(8'd65, 8'd8));
      directed_rows.insert(directed_rows.size(), load_row(8'd32, 8'd16));
      directed_rows.insert(directed_rows.size(), load_row(8'd0, 8'd255));
      directed_rows.insert(directed_rows.size(), load_row(8'd255, 8'd0));
      directed_rows.insert(directed_rows.size(), typed_row(
         char_row(8'd65, 1'b1, 32'h0, 32'h0, 32'h0, 31'h0010_0000),
         '{32'h0, 32'h0008_0000, 32'h0010_0000, 32'h0, 32'h0,
           17'h01000, 17'h01800, 17'h02000, 17'h03000}));
      // Cursor carries over from the previous glyph
      directed_rows.insert(directed_rows.size(), typed_row(
         char_row(8'd32, 1'b0, 32'h1234_5678, 32'h0001_0000, 32'hFFFF_FFFF, 31'h0001_0000),
         '{32'h0008_0000, 32'h0009_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_FFFF,
           17'h0, 17'h01000, 17'h0, 17'h01000}));
      // Code below base, largest positions and size: x and y saturate
      directed_rows.insert(directed_rows.size(), typed_row(
         char_row(8'd0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF),
         '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
           17'h0, 17'h0FF00, 17'h0, 17'h01000}));
      directed_rows.insert(directed_rows.size(), typed_row(
         char_row(8'd0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0),
         '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
           17'h0, 17'h0FF00, 17'h0, 17'h01000}));
      // Last code with zero width: last column of row 13
      directed_rows.insert(directed_rows.size(), typed_row(
         char_row(8'd255, 1'b1, 32'h0, 32'h0, 32'h0, 31'h0001_0000),
         '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
           17'h0F000, 17'h0F000, 17'h0D000, 17'h0E000}));
      directed_rows.insert(directed_rows.size(),
                           char_row(8'd65, 1'b0, 32'h0, 32'hFFF0_0000, 32'h0000_8000,
                                    31'h0003_8000));
      directed_rows.insert(directed_rows.size(), load_row(8'd65, 8'd255));
      directed_rows.insert(directed_rows.size(),
                           char_row(8'd65, 1'b1, 32'hFFFF_0000, 32'h0100_0000, 32'h0,
                                    31'h0020_0000));
      directed_rows.insert(directed_rows.size(), load_row(8'd128, 8'd1));
      directed_rows.insert(directed_rows.size(),
                           char_row(8'd128, 1'b0, 32'h0, 32'h0, 32'h4000_0000,
                                    31'h0000_ABCD));
      directed_rows.insert(directed_rows.size(),
                           char_row(8'd32, 1'b0, 32'h0, 32'h7FF0_0000, 32'h0,
                                    31'h0100_0000));
      directed_rows.insert(directed_rows.size(),
                           char_row(8'd255, 1'b0, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA,
                                    31'h2AAA_AAAA));
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
      end

      // Smallest cells on the largest sheet, then the reverse (texture clamps),
      // then zero sizes, then two random settings
      phase_cfg[0] = '{8'd0, 11'd1, 11'd1, 13'd4096, 13'd4096};
      phase_cfg[1] = '{8'd255, 11'd1024, 11'd1024, 13'd1, 13'd1};
      phase_cfg[2] = '{8'd100, 11'd0, 11'd0, 13'd0, 13'd0};
      phase_cfg[3] = '{8'($urandom), 11'($urandom_range(1, 1024)),
                       11'($urandom_range(1, 1024)), 13'($urandom_range(1, 4096)),
                       13'($urandom_range(1, 4096))};
      phase_cfg[4] = '{8'($urandom_range(0, 64)), 11'($urandom_range(1, 64)),
                       11'($urandom_range(1, 64)), 13'($urandom_range(64, 4096)),
                       13'($urandom_range(64, 4096))};
      for (int p = 0; p < 5; p++) begin
         apply_settings(phase_cfg[p]);
         steady = (p == 4);
         for (int k = 0; k < RANDOM_PER_CFG; k++) begin
            if (p == 3 && k == RANDOM_PER_CFG / 2) begin
               drain();
            end
            send_item(random_row());
         end
      end

      drain();
      if (vertex_queue.size() != 0) begin
         report_mismatch($sformatf("%0d vertices never arrived", vertex_queue.size()));
      end
      $display("Ran %0d width loads and %0d glyphs, checked %0d vertices",
               loads_sent, glyphs_sent, vertices_seen);
      $display("Register settings applied after reset: %0d, mismatches: %0d",
               settings_used, error_count);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
